// ----- rtl/armax_pkg.sv -----
// Shared package for the ARMAX one-step predictor.
// Holds the configuration register map, the config struct and the fixed-point constants.
// No dependencies.
package armax_pkg;

  // Fixed-point format of the coefficients: signed Q2.14
  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 14;
  localparam int COEF_SLOTS = 4;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int ORD_W      = 3;
  localparam int DLY_W      = 4;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ORDER   = 4;
  localparam int DEF_MAX_DELAY   = 8;
  localparam int DEF_SAMPLE_BITS = 16;

  // Reset values of the order and delay registers
  localparam logic [ORD_W-1:0] RST_AR_ORDER    = 3'd0;
  localparam logic [ORD_W-1:0] RST_INPUT_ORDER = 3'd1;
  localparam logic [ORD_W-1:0] RST_MA_ORDER    = 3'd0;
  localparam logic [DLY_W-1:0] RST_INPUT_DELAY = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_COEFS     = 3'd0,
    REG_B_COEFS     = 3'd1,
    REG_C_COEFS     = 3'd2,
    REG_AR_ORDER    = 3'd3,
    REG_INPUT_ORDER = 3'd4,
    REG_MA_ORDER    = 3'd5,
    REG_INPUT_DELAY = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] a_coefs;
    logic [CFG_DATA_W-1:0] b_coefs;
    logic [CFG_DATA_W-1:0] c_coefs;
    logic [ORD_W-1:0]      ar_order;
    logic [ORD_W-1:0]      input_order;
    logic [ORD_W-1:0]      ma_order;
    logic [DLY_W-1:0]      input_delay;
  } cfg_t;

endpackage

// ----- rtl/armax_cfg.sv -----
// Configuration register file of the ARMAX predictor.
// Decodes register writes into a cfg_t; unknown indexes are dropped.
// Depends on armax_pkg.
module armax_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [armax_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [armax_pkg::CFG_DATA_W-1:0]  wr_data,
  output armax_pkg::cfg_t                   cfg
);
  import armax_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_A_COEFS:     cfg_nxt.a_coefs     = wr_data;
        REG_B_COEFS:     cfg_nxt.b_coefs     = wr_data;
        REG_C_COEFS:     cfg_nxt.c_coefs     = wr_data;
        REG_AR_ORDER:    cfg_nxt.ar_order    = wr_data[ORD_W-1:0];
        REG_INPUT_ORDER: cfg_nxt.input_order = wr_data[ORD_W-1:0];
        REG_MA_ORDER:    cfg_nxt.ma_order    = wr_data[ORD_W-1:0];
        REG_INPUT_DELAY: cfg_nxt.input_delay = wr_data[DLY_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_coefs     <= '0;
      cfg_r.b_coefs     <= '0;
      cfg_r.c_coefs     <= '0;
      cfg_r.ar_order    <= RST_AR_ORDER;
      cfg_r.input_order <= RST_INPUT_ORDER;
      cfg_r.ma_order    <= RST_MA_ORDER;
      cfg_r.input_delay <= RST_INPUT_DELAY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/armax_hist.sv -----
// History lines of the ARMAX predictor: past inputs, outputs and residuals.
// Presents restart-masked taps and shifts in the current sample on each advance.
// Depends on armax_pkg.
module armax_hist #(
  parameter int SB       = armax_pkg::DEF_SAMPLE_BITS,
  parameter int NT       = armax_pkg::DEF_MAX_ORDER,
  parameter int IN_DEPTH = armax_pkg::DEF_MAX_DELAY + armax_pkg::DEF_MAX_ORDER
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic                restart,
  input  logic signed [SB-1:0] u_in,
  input  logic signed [SB-1:0] y_in,
  input  logic signed [SB:0]   eps_in,
  output logic signed [SB-1:0] u_tap [IN_DEPTH],
  output logic signed [SB-1:0] y_tap [NT],
  output logic signed [SB:0]   e_tap [NT]
);
  import armax_pkg::*;

  logic signed [SB-1:0] u_hist_r   [IN_DEPTH];
  logic signed [SB-1:0] u_hist_nxt [IN_DEPTH];
  logic signed [SB-1:0] y_hist_r   [NT];
  logic signed [SB-1:0] y_hist_nxt [NT];
  logic signed [SB:0]   e_hist_r   [NT];
  logic signed [SB:0]   e_hist_nxt [NT];

  // restart makes the whole record start from zero for this sample
  always_comb begin
    for (int i = 0; i < IN_DEPTH; i++) begin
      u_tap[i] = restart ? '0 : u_hist_r[i];
    end
    for (int i = 0; i < NT; i++) begin
      y_tap[i] = restart ? '0 : y_hist_r[i];
      e_tap[i] = restart ? '0 : e_hist_r[i];
    end
  end

  always_comb begin
    u_hist_nxt = u_hist_r;
    y_hist_nxt = y_hist_r;
    e_hist_nxt = e_hist_r;
    if (shift_en) begin
      u_hist_nxt[0] = u_in;
      y_hist_nxt[0] = y_in;
      e_hist_nxt[0] = eps_in;
      for (int i = 1; i < IN_DEPTH; i++) begin
        u_hist_nxt[i] = u_tap[i-1];
      end
      for (int i = 1; i < NT; i++) begin
        y_hist_nxt[i] = y_tap[i-1];
        e_hist_nxt[i] = e_tap[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IN_DEPTH; i++) begin
        u_hist_r[i] <= '0;
      end
      for (int i = 0; i < NT; i++) begin
        y_hist_r[i] <= '0;
        e_hist_r[i] <= '0;
      end
    end else begin
      u_hist_r <= u_hist_nxt;
      y_hist_r <= y_hist_nxt;
      e_hist_r <= e_hist_nxt;
    end
  end

endmodule

// ----- rtl/armax_dp.sv -----
// Prediction datapath: parallel multiplies of the AR, input and MA terms,
// full-width sum, round half up, saturate, and the exact residual.
// Depends on armax_pkg.
module armax_dp #(
  parameter int SB        = armax_pkg::DEF_SAMPLE_BITS,
  parameter int NT        = armax_pkg::DEF_MAX_ORDER,
  parameter int MAX_DELAY = armax_pkg::DEF_MAX_DELAY,
  parameter int IN_DEPTH  = armax_pkg::DEF_MAX_DELAY + armax_pkg::DEF_MAX_ORDER
) (
  input  armax_pkg::cfg_t      cfg,
  input  logic signed [SB-1:0] u_cur,
  input  logic signed [SB-1:0] y_cur,
  input  logic signed [SB-1:0] u_tap [IN_DEPTH],
  input  logic signed [SB-1:0] y_tap [NT],
  input  logic signed [SB:0]   e_tap [NT],
  output logic signed [SB-1:0] y_hat,
  output logic signed [SB:0]   eps
);
  import armax_pkg::*;

  localparam int PROD_W = COEF_W + SB + 1;
  localparam int ACC_W  = PROD_W + 4;
  localparam int LAG_W  = $clog2(MAX_DELAY + NT + 1);
  localparam int IDX_W  = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  // signed zero keeps the lane products signed inside the select
  localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;

  logic [LAG_W-1:0]        nk;
  logic [LAG_W-1:0]        lag      [NT];
  logic signed [SB-1:0]    u_sel    [NT];
  logic signed [PROD_W-1:0] prod_a  [NT];
  logic signed [PROD_W-1:0] prod_b  [NT];
  logic signed [PROD_W-1:0] prod_c  [NT];
  logic signed [ACC_W-1:0] lane_sum [NT];
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] q;
  logic signed [ACC_W-1:0] q_int;
  logic [ACC_W-SB:0]       q_top;

  // dead time saturates at MAX_DELAY
  assign nk = (32'(cfg.input_delay) > 32'(MAX_DELAY)) ? LAG_W'(MAX_DELAY)
                                                       : LAG_W'(cfg.input_delay);

  // one lane per coefficient slot; a lane at or beyond its order adds zero
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      lag[i]   = nk + LAG_W'(i);
      u_sel[i] = (lag[i] == '0) ? u_cur : u_tap[IDX_W'(lag[i] - LAG_W'(1))];
      prod_a[i] = (ORD_W'(i) < cfg.ar_order)
                ? signed'(cfg.a_coefs[COEF_W*i +: COEF_W]) * y_tap[i] : PROD_ZERO;
      prod_b[i] = (ORD_W'(i) < cfg.input_order)
                ? signed'(cfg.b_coefs[COEF_W*i +: COEF_W]) * u_sel[i] : PROD_ZERO;
      prod_c[i] = (ORD_W'(i) < cfg.ma_order)
                ? signed'(cfg.c_coefs[COEF_W*i +: COEF_W]) * e_tap[i] : PROD_ZERO;
      lane_sum[i] = ACC_W'(prod_b[i]) + ACC_W'(prod_c[i]) - ACC_W'(prod_a[i]);
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NT; i++) begin
      acc = acc + lane_sum[i];
    end
  end

  // round half toward plus infinity: add half, arithmetic shift floors
  assign q     = acc + signed'(ROUND_HALF);
  assign q_int = q >>> FRAC_BITS;
  assign q_top = q_int[ACC_W-1:SB-1];

  always_comb begin
    if ((&q_top) || !(|q_top)) begin
      y_hat = q_int[SB-1:0];
    end else if (q_int[ACC_W-1]) begin
      y_hat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_hat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  assign eps = {y_cur[SB-1], y_cur} - {y_hat[SB-1], y_hat};

endmodule

// ----- rtl/armax_one_step_predictor.sv -----
// Top level of the ARMAX one-step-ahead predictor.
// Instantiates armax_cfg, armax_hist and armax_dp; depends on armax_pkg.
//
//  channel | ports                                          | flow control
//  --------+------------------------------------------------+-----------------------
//  in      | in_restart, in_u_sample, in_y_sample           | in_valid / in_stall
//  out     | out_predicted_output, out_residual             | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                            | cfg_valid / cfg_ready
//
// One sample per cycle sustained while out_stall is low. A sample lands in the
// input register on its transfer and its result is registered in the output
// register, setting out_valid, once free. The loop that sets the rate is the
// residual feedback: eps(t-1) must be in the history before sample t is
// predicted, and it is written back the same edge the result is registered.
// Reset (rst_n low, synchronous) empties both stages, zeroes all history and
// loads the register defaults. in_stall rises only while both stages hold a
// sample and out_stall is high. cfg_ready is always high.
module armax_one_step_predictor #(
  parameter int MAX_ORDER   = armax_pkg::DEF_MAX_ORDER,
  parameter int MAX_DELAY   = armax_pkg::DEF_MAX_DELAY,
  parameter int SAMPLE_BITS = armax_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_restart,
  input  logic signed [SAMPLE_BITS-1:0]      in_u_sample,
  input  logic signed [SAMPLE_BITS-1:0]      in_y_sample,
  // prediction output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_predicted_output,
  output logic signed [SAMPLE_BITS:0]        out_residual,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [armax_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [armax_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import armax_pkg::*;

  // only the first COEF_SLOTS lags have coefficients, deeper history never matters
  localparam int NTERMS   = (MAX_ORDER < COEF_SLOTS) ? MAX_ORDER : COEF_SLOTS;
  localparam int IN_DEPTH = MAX_DELAY + NTERMS;
  localparam int SB       = SAMPLE_BITS;

  cfg_t cfg;

  // input register stage
  logic                 s0_valid_r, s0_valid_nxt;
  logic                 s0_restart_r;
  logic signed [SB-1:0] s0_u_r;
  logic signed [SB-1:0] s0_y_r;

  // output register stage
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SB-1:0] pred_r;
  logic signed [SB:0]   resid_r;

  logic                 in_xfer;
  logic                 out_free;
  logic                 advance;

  logic signed [SB-1:0] u_tap [IN_DEPTH];
  logic signed [SB-1:0] y_tap [NTERMS];
  logic signed [SB:0]   e_tap [NTERMS];
  logic signed [SB-1:0] y_hat;
  logic signed [SB:0]   eps;

  assign cfg_ready = 1'b1;

  armax_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake: output register frees on its transfer, input stage advances into it
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s0_valid_r && out_free;
  assign in_stall = s0_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_xfer) begin
      s0_valid_nxt = 1'b1;
    end else if (advance) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_restart_r <= in_restart;
      s0_u_r       <= in_u_sample;
      s0_y_r       <= in_y_sample;
    end
    if (advance) begin
      pred_r  <= y_hat;
      resid_r <= eps;
    end
  end

  // history shifts exactly when a sample's result is registered
  armax_hist #(
    .SB       (SB),
    .NT       (NTERMS),
    .IN_DEPTH (IN_DEPTH)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (advance),
    .restart  (s0_restart_r),
    .u_in     (s0_u_r),
    .y_in     (s0_y_r),
    .eps_in   (eps),
    .u_tap    (u_tap),
    .y_tap    (y_tap),
    .e_tap    (e_tap)
  );

  armax_dp #(
    .SB        (SB),
    .NT        (NTERMS),
    .MAX_DELAY (MAX_DELAY),
    .IN_DEPTH  (IN_DEPTH)
  ) u_dp (
    .cfg   (cfg),
    .u_cur (s0_u_r),
    .y_cur (s0_y_r),
    .u_tap (u_tap),
    .y_tap (y_tap),
    .e_tap (e_tap),
    .y_hat (y_hat),
    .eps   (eps)
  );

  assign out_valid            = out_valid_r;
  assign out_predicted_output = pred_r;
  assign out_residual         = resid_r;

endmodule

// ----- rtl/armax_chk.sv -----
// Port-level checker for armax_one_step_predictor, bound to the top level.
// Depends on armax_pkg.
module armax_chk #(
  parameter int SAMPLE_BITS = armax_pkg::DEF_SAMPLE_BITS
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_restart,
  input logic signed [SAMPLE_BITS-1:0]     in_u_sample,
  input logic signed [SAMPLE_BITS-1:0]     in_y_sample,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [SAMPLE_BITS-1:0]     out_predicted_output,
  input logic signed [SAMPLE_BITS:0]       out_residual,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [armax_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [armax_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import armax_pkg::*;

  // input backs up only behind a blocked, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked output");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_predicted_output) && $stable(out_residual)))
    else $error("stalled result changed");

  // an accepted sample reaches the output once the output register drains
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted sample did not reach the output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind armax_one_step_predictor armax_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_armax_chk (.*);

// ----- tb/armax_predict_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the ARMAX one-step predictor: watches the cfg, in and out channels,
// keeps its own registers and history lines, and compares each result field by field.
// Depends on armax_pkg.
module armax_predict_checker #(
  parameter int MAX_ORDER   = armax_pkg::DEF_MAX_ORDER,
  parameter int MAX_DELAY   = armax_pkg::DEF_MAX_DELAY,
  parameter int SAMPLE_BITS = armax_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_restart,
  input  logic signed [SAMPLE_BITS-1:0]     in_u_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_y_sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [SAMPLE_BITS-1:0]     out_predicted_output,
  input  logic signed [SAMPLE_BITS:0]       out_residual,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [armax_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [armax_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                       fail_count,
  output int unsigned                       pending_count
);
  import armax_pkg::*;

  localparam int     IN_DEPTH = MAX_ORDER + MAX_DELAY;
  localparam longint SAT_HI   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO   = -SAT_HI - 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] predicted;
    logic [SAMPLE_BITS:0]   residual;
  } prediction_t;

  cfg_t                          regs;
  logic signed [SAMPLE_BITS-1:0] u_line   [IN_DEPTH];
  logic signed [SAMPLE_BITS-1:0] y_line   [MAX_ORDER];
  logic signed [SAMPLE_BITS:0]   eps_line [MAX_ORDER];
  prediction_t                   predictions_due [$];
  int unsigned                   fails = 0;

  function automatic void clear_lines();
    foreach (u_line[i]) u_line[i] = '0;
    foreach (y_line[i]) y_line[i] = '0;
    foreach (eps_line[i]) eps_line[i] = '0;
  endfunction

  function automatic longint coef_slot(logic [CFG_DATA_W-1:0] bank, int i);
    if (i >= COEF_SLOTS) return 0;
    return longint'($signed(bank[COEF_W*i +: COEF_W]));
  endfunction

  function automatic int clamp_to(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  // One time step: sum of AR, input and MA terms, round, saturate, then shift history
  function automatic prediction_t predict_sample(logic restart,
                                                 logic signed [SAMPLE_BITS-1:0] u,
                                                 logic signed [SAMPLE_BITS-1:0] y);
    int          na, nb, nc, nk, lag;
    longint      acc, yh, eps;
    prediction_t p;
    na = clamp_to(int'(regs.ar_order), MAX_ORDER);
    nb = clamp_to(int'(regs.input_order), MAX_ORDER);
    nc = clamp_to(int'(regs.ma_order), MAX_ORDER);
    nk = clamp_to(int'(regs.input_delay), MAX_DELAY);
    if (restart) clear_lines();
    acc = 0;
    for (int i = 0; i < na; i++) acc -= coef_slot(regs.a_coefs, i) * longint'(y_line[i]);
    for (int i = 0; i < nb; i++) begin
      lag = nk + i;
      if (lag == 0) acc += coef_slot(regs.b_coefs, i) * longint'(u);
      else if (lag <= IN_DEPTH) acc += coef_slot(regs.b_coefs, i) * longint'(u_line[lag-1]);
    end
    for (int i = 0; i < nc; i++) acc += coef_slot(regs.c_coefs, i) * longint'(eps_line[i]);
    // half LSB up, then floor
    yh = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (yh > SAT_HI) yh = SAT_HI;
    else if (yh < SAT_LO) yh = SAT_LO;
    eps = longint'(y) - yh;
    for (int i = IN_DEPTH - 1; i > 0; i--) u_line[i] = u_line[i-1];
    for (int i = MAX_ORDER - 1; i > 0; i--) begin
      y_line[i]   = y_line[i-1];
      eps_line[i] = eps_line[i-1];
    end
    u_line[0]   = u;
    y_line[0]   = y;
    eps_line[0] = eps[SAMPLE_BITS:0];
    p.predicted = yh[SAMPLE_BITS-1:0];
    p.residual  = eps[SAMPLE_BITS:0];
    return p;
  endfunction

  always @(posedge clk) begin
    prediction_t want;
    if (!rst_n) begin
      regs             = '0;
      regs.ar_order    = RST_AR_ORDER;
      regs.input_order = RST_INPUT_ORDER;
      regs.ma_order    = RST_MA_ORDER;
      regs.input_delay = RST_INPUT_DELAY;
      clear_lines();
      predictions_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_A_COEFS:     regs.a_coefs     = cfg_data;
          REG_B_COEFS:     regs.b_coefs     = cfg_data;
          REG_C_COEFS:     regs.c_coefs     = cfg_data;
          REG_AR_ORDER:    regs.ar_order    = cfg_data[ORD_W-1:0];
          REG_INPUT_ORDER: regs.input_order = cfg_data[ORD_W-1:0];
          REG_MA_ORDER:    regs.ma_order    = cfg_data[ORD_W-1:0];
          REG_INPUT_DELAY: regs.input_delay = cfg_data[DLY_W-1:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (in_valid && !in_stall)
        predictions_due.push_back(predict_sample(in_restart, in_u_sample, in_y_sample));
      if (out_valid && !out_stall) begin
        if (predictions_due.size() == 0) begin
          $display("%0t: unexpected result: predicted %0d residual %0d", $time,
                   out_predicted_output, out_residual);
          fails++;
        end else begin
          want = predictions_due.pop_front();
          if (out_predicted_output !== want.predicted) begin
            $display("%0t: predicted_output expected %0d actual %0d", $time,
                     $signed(want.predicted), out_predicted_output);
            fails++;
          end
          if (out_residual !== want.residual) begin
            $display("%0t: residual expected %0d actual %0d", $time,
                     $signed(want.residual), out_residual);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= predictions_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the ARMAX one-step predictor testbench: clock, reset, stimulus and verdict.
// Depends on armax_pkg, armax_one_step_predictor and armax_predict_checker.
module tb_top;
  import armax_pkg::*;

  localparam int                 SB           = DEF_SAMPLE_BITS;
  localparam int                 RANDOM_ITEMS = 450;
  localparam int                 STALL_LIMIT  = 2000;  // cycles with no transfer at all
  // index 7 has no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE   = 3'd7;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_restart  = 1'b0;
  logic [SB-1:0]          in_u_sample = '0;
  logic [SB-1:0]          in_y_sample = '0;
  logic                   out_stall   = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic                   cfg_ready;
  logic signed [SB-1:0]   out_predicted_output;
  logic signed [SB:0]     out_residual;
  int unsigned            n_fail;
  int unsigned            n_pending;

  // Idle-insertion modes; calm means no waits on that side for the phase
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int idle_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  armax_one_step_predictor i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_restart           (in_restart),
    .in_u_sample          (in_u_sample),
    .in_y_sample          (in_y_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_predicted_output (out_predicted_output),
    .out_residual         (out_residual),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  armax_predict_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_restart           (in_restart),
    .in_u_sample          (in_u_sample),
    .in_y_sample          (in_y_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_predicted_output (out_predicted_output),
    .out_residual         (out_residual),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (n_fail),
    .pending_count        (n_pending)
  );

  // Wait before the next transfer, skewed toward short waits; none when calm
  function automatic int draw_wait(bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 19);
      1:       return $urandom_range(0, 3);
      default: return 0;
    endcase
  endfunction

  // Sample values: rails, full random, and small values that keep the sums unsaturated
  function automatic logic [SB-1:0] draw_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  // Four Q2.14 slots of one style: random, small, rails, or zero
  function automatic logic [CFG_DATA_W-1:0] draw_coef_bank();
    logic [CFG_DATA_W-1:0] bank;
    int                    style;
    style = $urandom_range(0, 5);
    bank  = '0;
    for (int s = 0; s < COEF_SLOTS; s++) begin
      case (style)
        0:       bank[COEF_W*s +: COEF_W] = 16'($urandom);
        1, 2, 3: bank[COEF_W*s +: COEF_W] = 16'($urandom_range(0, 8191) - 4096);
        4:       bank[COEF_W*s +: COEF_W] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: bank[COEF_W*s +: COEF_W] = '0;
      endcase
    end
    return bank;
  endfunction

  // Orders 0..4 mostly, sometimes 5..7 to hit the clamp
  function automatic logic [CFG_DATA_W-1:0] draw_order();
    return CFG_DATA_W'(($urandom_range(0, 4) == 0) ? $urandom_range(5, 7)
                                                   : $urandom_range(0, 4));
  endfunction

  // One register write; cfg_valid is left high so back-to-back writes need no bubble
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // One sample transfer after a drawn gap; in_valid stays high on return
  task automatic send_sample(input logic restart, input logic [SB-1:0] u,
                             input logic [SB-1:0] y);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_restart  <= restart;
    in_u_sample <= u;
    in_y_sample <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // Pending count is registered in the checker, so the loop waits on the clock before each check
  task automatic wait_drained();
    do @(posedge clk); while (n_pending != 0);
  endtask

  // Result side: fresh stall budget after each transfer, counted down per cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_hold = draw_wait(rx_calm);
      else if (rx_hold > 0) rx_hold = rx_hold - 1;
      out_stall <= (rx_hold > 0);
    end
  end

  // Watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                    sent;
    int                    burst;
    int                    pause_at;
    logic [CFG_DATA_W-1:0] fir_taps;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // --- Reset defaults: b is zero, so the prediction is 0 and residual equals y.
    // Rails on y give the widest residual of either sign.
    send_sample(1'b1, 16'h7FFF, 16'h7FFF);
    send_sample(1'b0, 16'h8000, 16'h8000);
    send_sample(1'b0, 16'h0000, 16'h7FFF);
    in_valid <= 1'b0;
    wait_drained();

    // --- Rails on every coefficient, all orders above the limit, zero dead time.
    // b1 near +2 on a rail input drives y_hat into saturation both ways;
    // the unmapped index write must leave everything alone.
    write_reg(REG_A_COEFS,     64'h8000_8000_8000_8000);
    write_reg(REG_B_COEFS,     64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_C_COEFS,     64'h8000_8000_8000_8000);
    write_reg(REG_AR_ORDER,    64'd7);
    write_reg(REG_INPUT_ORDER, 64'd7);
    write_reg(REG_MA_ORDER,    64'd7);
    write_reg(REG_INPUT_DELAY, 64'd0);
    write_reg(REG_NONE,        64'hFFFF_FFFF_FFFF_FFFF);
    cfg_valid <= 1'b0;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_sample(1'b1, 16'h7FFF, 16'h8000);
    send_sample(1'b0, 16'h7FFF, 16'h8000);
    send_sample(1'b0, 16'h8000, 16'h7FFF);
    send_sample(1'b0, 16'h8000, 16'h7FFF);
    send_sample(1'b0, 16'h8000, 16'h7FFF);
    send_sample(1'b1, 16'h8000, 16'h7FFF);
    send_sample(1'b0, 16'h0000, 16'h0000);
    send_sample(1'b0, 16'hFFFF, 16'h0001);
    in_valid <= 1'b0;
    wait_drained();

    // --- Pure FIR at the deepest lag: delay above the limit clamps to the max,
    // four taps reach the deepest lags the datapath can select. Restart midway empties it.
    fir_taps = draw_coef_bank();
    write_reg(REG_A_COEFS,     64'h7FFF_8000_7FFF_8000);
    write_reg(REG_B_COEFS,     fir_taps);
    write_reg(REG_C_COEFS,     64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_AR_ORDER,    64'd0);
    write_reg(REG_INPUT_ORDER, 64'd4);
    write_reg(REG_MA_ORDER,    64'd0);
    write_reg(REG_INPUT_DELAY, 64'd15);
    cfg_valid <= 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    for (int k = 0; k < 12; k++) send_sample(k == 6, draw_sample(), draw_sample());
    in_valid <= 1'b0;
    wait_drained();

    // --- Random phases: new settings each time, both sides idle at random,
    // some phases run back to back with no waits at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_reg(REG_A_COEFS,     draw_coef_bank());
      write_reg(REG_B_COEFS,     draw_coef_bank());
      write_reg(REG_C_COEFS,     draw_coef_bank());
      write_reg(REG_AR_ORDER,    draw_order());
      write_reg(REG_INPUT_ORDER, draw_order());
      write_reg(REG_MA_ORDER,    draw_order());
      write_reg(REG_INPUT_DELAY,
                CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                        : $urandom_range(0, 8)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, {$urandom, $urandom});
      cfg_valid <= 1'b0;
      tx_calm  = ($urandom_range(0, 3) == 0);
      rx_calm  = ($urandom_range(0, 3) == 0);
      burst    = $urandom_range(15, 60);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      pause_at = $urandom_range(0, burst - 1);
      for (int k = 0; k < burst; k++) begin
        send_sample($urandom_range(0, 19) == 0, draw_sample(), draw_sample());
        // sender holds off until the pipe is empty, then resumes mid-record
        if (k == pause_at && $urandom_range(0, 1) == 0) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      sent += burst;
      in_valid <= 1'b0;
      wait_drained();
    end

    // Drained; keep the clock running to catch any stray result
    repeat (8) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
